FILE: src/point_reflect_across_line_defines.svh
// ----------------------------------------------------------------------------
// Point reflection assertion macros
// Shared assertion forms for the point reflection block.
// ----------------------------------------------------------------------------
`ifndef POINT_REFLECT_ACROSS_LINE_DEFINES_SVH
`define POINT_REFLECT_ACROSS_LINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PRL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("point reflection check failed");

// Next-cycle implication, checked at every edge.
`define PRL_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("point reflection check failed");

`endif

FILE: src/prl_pkg.sv
// ----------------------------------------------------------------------------
// Point reflection package
// Widths, transaction types and stage payload types shared by the block.
// ----------------------------------------------------------------------------
package prl_pkg;

   localparam int COORD_BITS = 24;
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int DOT_BITS = PROD_BITS + 1;
   localparam int SPLIT_BITS = DOT_BITS / 2;
   localparam int NUM_BITS = DIFF_BITS + DOT_BITS;
   localparam int DIVIDEND_BITS = NUM_BITS + 1;
   localparam int DEN_BITS = DOT_BITS + 1;
   localparam int QUO_BITS = COORD_BITS + 2;
   localparam int RES_BITS = COORD_BITS + 6;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] line_start_x;
      logic signed [COORD_BITS-1:0] line_start_y;
      logic signed [COORD_BITS-1:0] line_end_x;
      logic signed [COORD_BITS-1:0] line_end_y;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] mirrored_x;
      logic signed [COORD_BITS-1:0] mirrored_y;
      logic                         clipped;
   } rsp_type;

   typedef struct packed {
      logic                  vert;
      logic [COORD_BITS-1:0] sx;
      logic [COORD_BITS-1:0] sy;
      logic [COORD_BITS-1:0] px;
      logic [COORD_BITS-1:0] py;
   } side_type;

   typedef struct packed {
      logic                     neg_x;
      logic                     neg_y;
      logic [DIVIDEND_BITS-1:0] num_x;
      logic [DIVIDEND_BITS-1:0] num_y;
      logic [DEN_BITS-1:0]      den;
      side_type                 side;
   } div_in_type;

   typedef struct packed {
      logic                neg_x;
      logic                neg_y;
      logic [QUO_BITS-1:0] quo_x;
      logic [QUO_BITS-1:0] quo_y;
      side_type            side;
   } div_out_type;

endpackage

FILE: src/prl_front.sv
// ----------------------------------------------------------------------------
// Point reflection front end
// Six stages: differences, products, dot and squared length, split products,
// numerator sums, then magnitude and rounding offset for the divider.
// ----------------------------------------------------------------------------
module prl_front import prl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  req_type    in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output div_in_type out_data
);

   localparam int STAGES = 6;

   typedef struct packed {
      logic signed [DIFF_BITS-1:0] dx;
      logic signed [DIFF_BITS-1:0] dy;
      logic signed [DIFF_BITS-1:0] vx;
      logic signed [DIFF_BITS-1:0] vy;
      side_type                    side;
   } s0_type;

   typedef struct packed {
      logic signed [PROD_BITS-1:0] pxx;
      logic signed [PROD_BITS-1:0] pyy;
      logic signed [PROD_BITS-1:0] lxx;
      logic signed [PROD_BITS-1:0] lyy;
      logic signed [DIFF_BITS-1:0] dx;
      logic signed [DIFF_BITS-1:0] dy;
      side_type                    side;
   } s1_type;

   typedef struct packed {
      logic signed [DOT_BITS-1:0]  dot;
      logic signed [DOT_BITS-1:0]  len2;
      logic signed [DIFF_BITS-1:0] dx;
      logic signed [DIFF_BITS-1:0] dy;
      side_type                    side;
   } s2_type;

   typedef struct packed {
      logic signed [NUM_BITS-1:0] lo_x;
      logic signed [NUM_BITS-1:0] hi_x;
      logic signed [NUM_BITS-1:0] lo_y;
      logic signed [NUM_BITS-1:0] hi_y;
      logic signed [DOT_BITS-1:0] len2;
      side_type                   side;
   } s3_type;

   typedef struct packed {
      logic signed [NUM_BITS-1:0] n_x;
      logic signed [NUM_BITS-1:0] n_y;
      logic signed [DOT_BITS-1:0] len2;
      side_type                   side;
   } s4_type;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] ready;
   s0_type     s0_ff, s0_in;
   s1_type     s1_ff, s1_in;
   s2_type     s2_ff, s2_in;
   s3_type     s3_ff, s3_in;
   s4_type     s4_ff, s4_in;
   div_in_type s5_ff, s5_in;

   always_comb begin
      for (int i = 0; i < STAGES - 1; i++) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      ready[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_data  = s5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int i = 1; i < STAGES; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   always_comb begin
      s0_in.dx = $signed({in_data.line_end_x[COORD_BITS-1], in_data.line_end_x})
               - $signed({in_data.line_start_x[COORD_BITS-1], in_data.line_start_x});
      s0_in.dy = $signed({in_data.line_end_y[COORD_BITS-1], in_data.line_end_y})
               - $signed({in_data.line_start_y[COORD_BITS-1], in_data.line_start_y});
      s0_in.vx = $signed({in_data.point_x[COORD_BITS-1], in_data.point_x})
               - $signed({in_data.line_start_x[COORD_BITS-1], in_data.line_start_x});
      s0_in.vy = $signed({in_data.point_y[COORD_BITS-1], in_data.point_y})
               - $signed({in_data.line_start_y[COORD_BITS-1], in_data.line_start_y});
      s0_in.side.vert = (in_data.line_start_x == in_data.line_end_x);
      s0_in.side.sx = in_data.line_start_x;
      s0_in.side.sy = in_data.line_start_y;
      s0_in.side.px = in_data.point_x;
      s0_in.side.py = in_data.point_y;
   end

   always_comb begin
      s1_in.pxx = s0_ff.dx * s0_ff.vx;
      s1_in.pyy = s0_ff.dy * s0_ff.vy;
      s1_in.lxx = s0_ff.dx * s0_ff.dx;
      s1_in.lyy = s0_ff.dy * s0_ff.dy;
      s1_in.dx = s0_ff.dx;
      s1_in.dy = s0_ff.dy;
      s1_in.side = s0_ff.side;
   end

   always_comb begin
      s2_in.dot = DOT_BITS'(s1_ff.pxx) + DOT_BITS'(s1_ff.pyy);
      s2_in.len2 = DOT_BITS'(s1_ff.lxx) + DOT_BITS'(s1_ff.lyy);
      s2_in.dx = s1_ff.dx;
      s2_in.dy = s1_ff.dy;
      s2_in.side = s1_ff.side;
   end

   always_comb begin
      s3_in.lo_x = s2_ff.dx * $signed({1'b0, s2_ff.dot[SPLIT_BITS-1:0]});
      s3_in.hi_x = s2_ff.dx * $signed(s2_ff.dot[DOT_BITS-1:SPLIT_BITS]);
      s3_in.lo_y = s2_ff.dy * $signed({1'b0, s2_ff.dot[SPLIT_BITS-1:0]});
      s3_in.hi_y = s2_ff.dy * $signed(s2_ff.dot[DOT_BITS-1:SPLIT_BITS]);
      s3_in.len2 = s2_ff.len2;
      s3_in.side = s2_ff.side;
   end

   always_comb begin
      s4_in.n_x = (s3_ff.hi_x <<< SPLIT_BITS) + s3_ff.lo_x;
      s4_in.n_y = (s3_ff.hi_y <<< SPLIT_BITS) + s3_ff.lo_y;
      s4_in.len2 = s3_ff.len2;
      s4_in.side = s3_ff.side;
   end

   always_comb begin
      logic [NUM_BITS-1:0] mag_x;
      logic [NUM_BITS-1:0] mag_y;
      mag_x = s4_ff.n_x[NUM_BITS-1] ? NUM_BITS'(-s4_ff.n_x) : NUM_BITS'(s4_ff.n_x);
      mag_y = s4_ff.n_y[NUM_BITS-1] ? NUM_BITS'(-s4_ff.n_y) : NUM_BITS'(s4_ff.n_y);
      s5_in.neg_x = s4_ff.n_x[NUM_BITS-1];
      s5_in.neg_y = s4_ff.n_y[NUM_BITS-1];
      s5_in.num_x = {mag_x, 1'b0} + DIVIDEND_BITS'(unsigned'(s4_ff.len2));
      s5_in.num_y = {mag_y, 1'b0} + DIVIDEND_BITS'(unsigned'(s4_ff.len2));
      s5_in.den = {s4_ff.len2, 1'b0};
      s5_in.side = s4_ff.side;
   end

   always_ff @(posedge clock) begin
      if (ready[0]) s0_ff <= s0_in;
      if (ready[1]) s1_ff <= s1_in;
      if (ready[2]) s2_ff <= s2_in;
      if (ready[3]) s3_ff <= s3_in;
      if (ready[4]) s4_ff <= s4_in;
      if (ready[5]) s5_ff <= s5_in;
   end

endmodule

FILE: src/prl_div.sv
// ----------------------------------------------------------------------------
// Point reflection divider
// Pipelined restoring divider, one quotient bit per stage, x and y in lanes.
// ----------------------------------------------------------------------------
module prl_div import prl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  div_in_type  in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output div_out_type out_data
);

   typedef struct packed {
      logic                neg_x;
      logic                neg_y;
      logic [DEN_BITS-1:0] rem_x;
      logic [DEN_BITS-1:0] rem_y;
      logic [QUO_BITS-1:0] sh_x;
      logic [QUO_BITS-1:0] sh_y;
      logic [DEN_BITS-1:0] den;
      side_type            side;
   } stage_type;

   function automatic logic [DEN_BITS:0] div_step(input logic [DEN_BITS-1:0] rem,
                                                  input logic                nbit,
                                                  input logic [DEN_BITS-1:0] den);
      logic [DEN_BITS:0] wide;
      logic [DEN_BITS:0] diff;
      wide = {rem, nbit};
      diff = wide - {1'b0, den};
      if (wide >= {1'b0, den}) begin
         return {diff[DEN_BITS-1:0], 1'b1};
      end
      return {wide[DEN_BITS-1:0], 1'b0};
   endfunction

   stage_type             entry;
   stage_type             src [QUO_BITS];
   stage_type             st_ff [QUO_BITS];
   stage_type             st_in [QUO_BITS];
   logic [QUO_BITS-1:0]   src_valid;
   logic [QUO_BITS-1:0]   valid_ff;
   logic [QUO_BITS-1:0]   ready;

   always_comb begin
      entry.neg_x = in_data.neg_x;
      entry.neg_y = in_data.neg_y;
      entry.rem_x = DEN_BITS'(in_data.num_x[DIVIDEND_BITS-1:QUO_BITS]);
      entry.rem_y = DEN_BITS'(in_data.num_y[DIVIDEND_BITS-1:QUO_BITS]);
      entry.sh_x = in_data.num_x[QUO_BITS-1:0];
      entry.sh_y = in_data.num_y[QUO_BITS-1:0];
      entry.den = in_data.den;
      entry.side = in_data.side;
   end

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
      logic [DEN_BITS:0] step_x;
      logic [DEN_BITS:0] step_y;

      if (i == 0) begin : g_first
         assign src[i] = entry;
         assign src_valid[i] = in_valid;
      end else begin : g_next
         assign src[i] = st_ff[i-1];
         assign src_valid[i] = valid_ff[i-1];
      end

      if (i == QUO_BITS - 1) begin : g_last
         assign ready[i] = !valid_ff[i] || out_ready;
      end else begin : g_mid
         assign ready[i] = !valid_ff[i] || ready[i+1];
      end

      always_comb begin
         step_x = div_step(src[i].rem_x, src[i].sh_x[QUO_BITS-1], src[i].den);
         step_y = div_step(src[i].rem_y, src[i].sh_y[QUO_BITS-1], src[i].den);
         st_in[i] = src[i];
         st_in[i].rem_x = step_x[DEN_BITS:1];
         st_in[i].rem_y = step_y[DEN_BITS:1];
         st_in[i].sh_x = {src[i].sh_x[QUO_BITS-2:0], step_x[0]};
         st_in[i].sh_y = {src[i].sh_y[QUO_BITS-2:0], step_y[0]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (ready[i]) begin
            valid_ff[i] <= src_valid[i];
         end
      end

      always_ff @(posedge clock) begin
         if (ready[i]) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign in_ready = ready[0];
   assign out_valid = valid_ff[QUO_BITS-1];
   assign out_data.neg_x = st_ff[QUO_BITS-1].neg_x;
   assign out_data.neg_y = st_ff[QUO_BITS-1].neg_y;
   assign out_data.quo_x = st_ff[QUO_BITS-1].sh_x;
   assign out_data.quo_y = st_ff[QUO_BITS-1].sh_y;
   assign out_data.side = st_ff[QUO_BITS-1].side;

endmodule

FILE: src/point_reflect_across_line.sv
// ----------------------------------------------------------------------------
// Point reflection across a line
// Mirrors a signed Q16.8 point across the line through two given points.
// ----------------------------------------------------------------------------
// A new transaction can enter every clock cycle unless rsp_ready stalls it;
// each passes six arithmetic stages, one divider stage per quotient bit, 26
// in all, and a saturating output register. A vertical line, which includes
// two equal line points, mirrors x only. A full output register lets the
// pipeline keep filling until every stage holds a transaction.
module point_reflect_across_line import prl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

`include "point_reflect_across_line_defines.svh"

   logic        front_valid;
   logic        front_ready;
   div_in_type  front_data;
   logic        div_valid;
   logic        div_ready;
   div_out_type div_data;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;

   prl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   prl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   assign div_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      logic signed [RES_BITS-1:0] sx;
      logic signed [RES_BITS-1:0] sy;
      logic signed [RES_BITS-1:0] px;
      logic signed [RES_BITS-1:0] py;
      logic signed [RES_BITS-1:0] ox;
      logic signed [RES_BITS-1:0] oy;
      logic signed [RES_BITS-1:0] rx;
      logic signed [RES_BITS-1:0] ry;
      logic                       clip_x;
      logic                       clip_y;
      sx = RES_BITS'($signed(div_data.side.sx));
      sy = RES_BITS'($signed(div_data.side.sy));
      px = RES_BITS'($signed(div_data.side.px));
      py = RES_BITS'($signed(div_data.side.py));
      ox = div_data.neg_x ? -RES_BITS'(div_data.quo_x) : RES_BITS'(div_data.quo_x);
      oy = div_data.neg_y ? -RES_BITS'(div_data.quo_y) : RES_BITS'(div_data.quo_y);
      if (div_data.side.vert) begin
         rx = (sx <<< 1) - px;
         ry = py;
      end else begin
         rx = ((sx + ox) <<< 1) - px;
         ry = ((sy + oy) <<< 1) - py;
      end
      clip_x = !(&rx[RES_BITS-1:COORD_BITS-1]) && (|rx[RES_BITS-1:COORD_BITS-1]);
      clip_y = !(&ry[RES_BITS-1:COORD_BITS-1]) && (|ry[RES_BITS-1:COORD_BITS-1]);
      rsp_in.mirrored_x = clip_x ? {rx[RES_BITS-1], {(COORD_BITS-1){!rx[RES_BITS-1]}}}
                                 : rx[COORD_BITS-1:0];
      rsp_in.mirrored_y = clip_y ? {ry[RES_BITS-1], {(COORD_BITS-1){!ry[RES_BITS-1]}}}
                                 : ry[COORD_BITS-1:0];
      rsp_in.clipped = clip_x || clip_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_ready) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `PRL_ASSERT_IMPL(a_clip_at_end, clock, reset,
      rsp_valid && rsp_data.clipped,
      (rsp_data.mirrored_x == {1'b0, {(COORD_BITS-1){1'b1}}}) ||
      (rsp_data.mirrored_x == {1'b1, {(COORD_BITS-1){1'b0}}}) ||
      (rsp_data.mirrored_y == {1'b0, {(COORD_BITS-1){1'b1}}}) ||
      (rsp_data.mirrored_y == {1'b1, {(COORD_BITS-1){1'b0}}}))
   `PRL_ASSERT_IMPL(a_den_nonzero, clock, reset,
      front_valid && !front_data.side.vert, front_data.den != '0)
   `PRL_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid)

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Point reflection testbench
// Sends directed and random point/line transactions through the mirror block.
// Each response is checked against an in-bench reflection calculation. Both
// handshakes are throttled at random except during the final phase.
// ----------------------------------------------------------------------------
module testbench import prl_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 80;
   localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type mirror_queue[$];
   bit      throttle = 1'b1;
   bit      failed = 1'b0;
   int      idle_cycles = 0;

   point_reflect_across_line u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic signed [127:0] round_quotient(logic signed [127:0] n,
                                                          logic signed [127:0] d);
      logic [127:0] mag;
      logic [127:0] q;
      mag = n < 0 ? -n : n;
      q = (2 * mag + d) / (2 * d);
      if (q > (128'd1 << 40)) q = 128'd1 << 40;
      return n < 0 ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic signed [COORD_BITS-1:0] saturate(logic signed [127:0] v,
                                                             ref bit clip);
      if (v > C_MAX) begin
         clip = 1'b1;
         return C_MAX;
      end
      if (v < C_MIN) begin
         clip = 1'b1;
         return C_MIN;
      end
      return v[COORD_BITS-1:0];
   endfunction

   function automatic rsp_type mirror_point(req_type r);
      logic signed [127:0] px, py, sx, sy, ex, ey;
      logic signed [127:0] dx, dy, dot, len2, rx, ry;
      bit clip;
      rsp_type o;
      px = r.point_x;
      py = r.point_y;
      sx = r.line_start_x;
      sy = r.line_start_y;
      ex = r.line_end_x;
      ey = r.line_end_y;
      clip = 1'b0;
      if (sx == ex) begin
         rx = 2 * sx - px;
         ry = py;
      end else begin
         dx = ex - sx;
         dy = ey - sy;
         dot = dx * (px - sx) + dy * (py - sy);
         len2 = dx * dx + dy * dy;
         rx = 2 * (sx + round_quotient(dx * dot, len2)) - px;
         ry = 2 * (sy + round_quotient(dy * dot, len2)) - py;
      end
      o.mirrored_x = saturate(rx, clip);
      o.mirrored_y = saturate(ry, clip);
      o.clipped = clip;
      return o;
   endfunction

   task automatic send_point(req_type item);
      if (throttle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      mirror_queue = {mirror_queue, mirror_point(item)};
   endtask

   function automatic logic signed [COORD_BITS-1:0] random_coord(bit near);
      if (near) return COORD_BITS'($signed($urandom_range(0, 8192)) - 4096);
      return COORD_BITS'($urandom);
   endfunction

   function automatic req_type make_req(int px, int py, int sx, int sy, int ex, int ey);
      req_type r;
      r.point_x = COORD_BITS'(px);
      r.point_y = COORD_BITS'(py);
      r.line_start_x = COORD_BITS'(sx);
      r.line_start_y = COORD_BITS'(sy);
      r.line_end_x = COORD_BITS'(ex);
      r.line_end_y = COORD_BITS'(ey);
      return r;
   endfunction

   task automatic test_directed();
      int mx, mn;
      mx = int'(C_MAX);
      mn = int'(C_MIN);
      send_point(make_req(mx, mx, mx, mx, mx, mx));
      send_point(make_req(mn, mn, mn, mn, mn, mn));
      send_point(make_req(mx, 5, mn, 0, mn, 100));
      send_point(make_req(mn, mx, mx, 0, mx, 0));
      send_point(make_req(300, -700, 256, 256, 256, 256));
      send_point(make_req(100, 200, -50, 10, 999, 10));
      send_point(make_req(mx, mn, 0, 0, 1000, 0));
      send_point(make_req(mn, mx, mn, mn, mx, mx));
      send_point(make_req(mx, mx, mn, mx, mx, mn));
      send_point(make_req(mn, mn, mx, mn, mn, mx));
      send_point(make_req(1, 0, 0, 0, 2, 1));
      send_point(make_req(1, 1, 0, 0, 2, 1));
      send_point(make_req(3, 0, 0, 0, 1, 1));
      send_point(make_req(-3, 1, 0, 0, 2, 2));
      send_point(make_req(0, 0, 1, 0, 0, 1));
      send_point(make_req(mx, 0, mn, mn, mn + 1, mx));
      send_point(make_req(0, mx, mx, mn, mn, mn + 1));
      send_point(make_req(12345, -6789, 1, 2, 3, 4));
      send_point(make_req(-1, -1, 0, 0, -1, 1));
      send_point(make_req(mn, 0, mx, 0, mx, mx));
   endtask

   task automatic test_random(int count, int near_pct);
      req_type r;
      bit near;
      repeat (count) begin
         near = $urandom_range(0, 99) < near_pct;
         r.point_x = random_coord(near);
         r.point_y = random_coord(near);
         r.line_start_x = random_coord(near);
         r.line_start_y = random_coord(near);
         case ($urandom_range(0, 7))
            0: begin
               r.line_end_x = r.line_start_x;
               r.line_end_y = random_coord(near);
            end
            1: begin
               r.line_end_x = random_coord(near);
               r.line_end_y = r.line_start_y;
            end
            2: begin
               r.line_end_x = r.line_start_x;
               r.line_end_y = r.line_start_y;
            end
            default: begin
               r.line_end_x = random_coord(near);
               r.line_end_y = random_coord(near);
            end
         endcase
         send_point(r);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (throttle && rsp_ready && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
      end else if (!rsp_ready) begin
         rsp_ready <= !throttle || $urandom_range(0, 2) == 0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (mirror_queue.size() == 0) begin
            $display("%0t: unexpected transaction, actual %h", $realtime, rsp_data);
            failed = 1'b1;
         end else begin
            want = mirror_queue.pop_front();
            if (rsp_data.mirrored_x !== want.mirrored_x) begin
               $display("%0t: mirrored_x expected %0d actual %0d", $realtime,
                        want.mirrored_x, rsp_data.mirrored_x);
               failed = 1'b1;
            end
            if (rsp_data.mirrored_y !== want.mirrored_y) begin
               $display("%0t: mirrored_y expected %0d actual %0d", $realtime,
                        want.mirrored_y, rsp_data.mirrored_y);
               failed = 1'b1;
            end
            if (rsp_data.clipped !== want.clipped) begin
               $display("%0t: clipped expected %0b actual %0b", $realtime,
                        want.clipped, rsp_data.clipped);
               failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(600, 80);
      test_random(600, 20);
      throttle = 1'b0;
      test_random(500, 50);
      req_valid <= 1'b0;
      while (mirror_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
